// ===== rtl/kwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsm_pkg: shared types and constants of the k-way sorted merge
// Defaults, port widths, the command and result formats and the state codes
// of the merge engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kwsm_pkg;

    localparam int MAX_LISTS_DEF    = 8;
    localparam int BUFFER_DEPTH_DEF = 8;
    localparam int KEY_WIDTH_DEF    = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CFG_W   = 4;
    localparam int IDX_W   = 3;
    localparam int VALUE_W = 32;

    typedef enum logic [0:0] {
        CMD_ELEM  = 1'b0,
        CMD_EMPTY = 1'b1
    } t_cmd_kind;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ERROR,
        BK_SETTLE,
        BK_DECIDE,
        BK_FETCH
    } t_back_state;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [IDX_W-1:0]          source_list;
        logic                      run_last;
        logic                      merge_done;
        logic                      overflow_error;
    } t_result;

    function automatic int f_list_w(input int ml);
        return (ml > 1) ? $clog2(ml) : 1;
    endfunction

    function automatic int f_lcnt_w(input int ml);
        return $clog2(ml + 1);
    endfunction

    function automatic int f_store_w(input int kw);
        return (kw < VALUE_W) ? kw : VALUE_W;
    endfunction

    function automatic int f_cmd_w(input int ml, input int kw);
        return 2 + f_list_w(ml) + f_store_w(kw);
    endfunction

endpackage

// ===== rtl/kwsm_ram.sv =====
// ----------------------------------------------------------------------------
// kwsm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kwsm_fifo.sv =====
// ----------------------------------------------------------------------------
// kwsm_fifo: small register-based queue
// Decouples the decode side from the merge engine and the engine from the
// result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwsm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kwsm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (w_rd) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/kwsm_front.sv =====
// ----------------------------------------------------------------------------
// kwsm_front: input decode and configuration
// Holds the lists-in-use register, drops inputs of lists not in use and
// turns every other input into a command for the merge engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwsm_front #(
    parameter int MAX_LISTS = kwsm_pkg::MAX_LISTS_DEF,
    parameter int KEY_WIDTH = kwsm_pkg::KEY_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [kwsm_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_in_push,
    output logic                                  o_in_full,
    input  logic [kwsm_pkg::IDX_W-1:0]            i_list_index,
    input  logic signed [kwsm_pkg::VALUE_W-1:0]   i_element_value,
    input  logic                                  i_list_final,
    input  logic                                  i_list_empty,
    input  logic                                  i_cmd_full,
    output logic                                  o_cmd_push,
    output logic [kwsm_pkg::f_cmd_w(MAX_LISTS, KEY_WIDTH)-1:0] o_cmd_data,
    output logic [kwsm_pkg::f_lcnt_w(MAX_LISTS)-1:0] o_lists
);

    localparam int CFG_W   = kwsm_pkg::CFG_W;
    localparam int LIST_W  = kwsm_pkg::f_list_w(MAX_LISTS);
    localparam int LCNT_W  = kwsm_pkg::f_lcnt_w(MAX_LISTS);
    localparam int STORE_W = kwsm_pkg::f_store_w(KEY_WIDTH);

    logic [LCNT_W-1:0]   r_lists, n_lists;
    logic                w_in_use;
    kwsm_pkg::t_cmd_kind w_kind;

    assign o_cfg_ready = 1'b1;
    assign o_lists     = r_lists;
    assign o_in_full   = i_cmd_full;

    // Out-of-range settings are clamped once, when written.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_lists = LCNT_W'(1);
        end else if (int'(i_cfg_data) > MAX_LISTS) begin
            n_lists = LCNT_W'(MAX_LISTS);
        end else begin
            n_lists = LCNT_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lists <= LCNT_W'(MAX_LISTS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lists <= n_lists;
        end
    end

    assign w_in_use   = (CFG_W'(i_list_index) < CFG_W'(r_lists));
    assign w_kind     = i_list_empty ? kwsm_pkg::CMD_EMPTY : kwsm_pkg::CMD_ELEM;
    assign o_cmd_push = i_in_push & ~i_cmd_full & w_in_use;
    assign o_cmd_data = {w_kind, i_list_index[LIST_W-1:0], i_list_final,
                         i_element_value[STORE_W-1:0]};

endmodule

// ===== rtl/kwsm_back.sv =====
// ----------------------------------------------------------------------------
// kwsm_back: merge engine
// Keeps a FIFO per list in a shared RAM with the head of each list in a
// register, picks the smallest head through a registered minimum tree and
// issues at most one result per decision and one per overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwsm_back #(
    parameter int MAX_LISTS    = kwsm_pkg::MAX_LISTS_DEF,
    parameter int BUFFER_DEPTH = kwsm_pkg::BUFFER_DEPTH_DEF,
    parameter int KEY_WIDTH    = kwsm_pkg::KEY_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [kwsm_pkg::f_lcnt_w(MAX_LISTS)-1:0] i_lists,
    input  logic                                  i_cmd_empty,
    input  logic [kwsm_pkg::f_cmd_w(MAX_LISTS, KEY_WIDTH)-1:0] i_cmd_data,
    output logic                                  o_cmd_pop,
    input  logic                                  i_res_full,
    output logic                                  o_res_push,
    output kwsm_pkg::t_result                     o_res_data
);

    localparam int LIST_W  = kwsm_pkg::f_list_w(MAX_LISTS);
    localparam int LCNT_W  = kwsm_pkg::f_lcnt_w(MAX_LISTS);
    localparam int STORE_W = kwsm_pkg::f_store_w(KEY_WIDTH);
    localparam int CMD_W   = kwsm_pkg::f_cmd_w(MAX_LISTS, KEY_WIDTH);
    localparam int IDX_W   = kwsm_pkg::IDX_W;
    localparam int VALUE_W = kwsm_pkg::VALUE_W;
    localparam int PTR_W   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int MEM_D   = MAX_LISTS * BUFFER_DEPTH;
    localparam int ADDR_W  = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int LV      = LIST_W;
    localparam int P       = 1 << LV;
    localparam int WAIT_W  = $clog2(LV + 1);

    kwsm_pkg::t_back_state r_state, n_state;

    logic [CNT_W-1:0]          r_cnt  [MAX_LISTS];
    logic [CNT_W-1:0]          n_cnt  [MAX_LISTS];
    logic [PTR_W-1:0]          r_rp   [MAX_LISTS];
    logic [PTR_W-1:0]          n_rp   [MAX_LISTS];
    logic                      r_end  [MAX_LISTS];
    logic                      n_end  [MAX_LISTS];
    logic signed [STORE_W-1:0] r_head [MAX_LISTS];
    logic signed [STORE_W-1:0] n_head [MAX_LISTS];

    logic                      r_pend, n_pend;
    logic signed [STORE_W-1:0] r_pkey, n_pkey;
    logic [LIST_W-1:0]         r_pidx, n_pidx;
    logic [WAIT_W-1:0]         r_wait, n_wait;

    logic                      w_nv [1:2*P-1];
    logic [LIST_W-1:0]         w_ni [1:2*P-1];
    logic signed [STORE_W-1:0] w_nk [1:2*P-1];
    logic                      r_nv [1:P-1];
    logic [LIST_W-1:0]         r_ni [1:P-1];
    logic signed [STORE_W-1:0] r_nk [1:P-1];

    kwsm_pkg::t_cmd_kind       w_kind;
    logic [LIST_W-1:0]         w_li;
    logic                      w_fin;
    logic signed [STORE_W-1:0] w_key;
    logic [SUM_W-1:0]          w_sum;
    logic [PTR_W-1:0]          w_slot;
    logic                      w_skip, w_full;

    logic                      w_stall, w_found, w_go, w_fetch;
    logic [LIST_W-1:0]         w_best;
    logic [PTR_W-1:0]          w_rp_nx;

    logic                      w_we;
    logic [ADDR_W-1:0]         w_waddr, w_raddr;
    logic [STORE_W-1:0]        w_rdata;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [LIST_W-1:0] li,
                                                 input logic [PTR_W-1:0] slot);
        return ADDR_W'(ADDR_W'(li) * ADDR_W'(BUFFER_DEPTH)) + ADDR_W'(slot);
    endfunction

    // Command fields
    assign w_kind = kwsm_pkg::t_cmd_kind'(i_cmd_data[CMD_W-1]);
    assign w_li   = i_cmd_data[CMD_W-2 -: LIST_W];
    assign w_fin  = i_cmd_data[STORE_W];
    assign w_key  = signed'(i_cmd_data[STORE_W-1:0]);
    assign w_skip = r_end[w_li];
    assign w_full = (r_cnt[w_li] == CNT_W'(BUFFER_DEPTH));
    assign w_sum  = SUM_W'(r_rp[w_li]) + SUM_W'(r_cnt[w_li]);
    assign w_slot = (w_sum >= SUM_W'(BUFFER_DEPTH)) ? PTR_W'(w_sum - SUM_W'(BUFFER_DEPTH))
                                                    : PTR_W'(w_sum);

    // Minimum tree: leaves are the list heads, every inner node is a register.
    for (genvar l = 0; l < P; l++) begin : g_leaf
        if (l < MAX_LISTS) begin : g_used
            assign w_nv[P+l] = (LCNT_W'(l) < i_lists) && (r_cnt[l] != '0);
            assign w_nk[P+l] = r_head[l];
        end else begin : g_pad
            assign w_nv[P+l] = 1'b0;
            assign w_nk[P+l] = '0;
        end
        assign w_ni[P+l] = LIST_W'(l);
    end

    for (genvar i = 1; i < P; i++) begin : g_node
        logic w_left;

        assign w_nv[i] = r_nv[i];
        assign w_ni[i] = r_ni[i];
        assign w_nk[i] = r_nk[i];
        assign w_left  = w_nv[2*i] && (!w_nv[2*i+1] || (w_nk[2*i] <= w_nk[2*i+1]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[i] <= 1'b0;
            end else begin
                r_nv[i] <= w_nv[2*i] | w_nv[2*i+1];
            end
            r_ni[i] <= w_left ? w_ni[2*i] : w_ni[2*i+1];
            r_nk[i] <= w_left ? w_nk[2*i] : w_nk[2*i+1];
        end
    end

    always_comb begin
        w_stall = 1'b0;
        for (int l = 0; l < MAX_LISTS; l++) begin
            if ((LCNT_W'(l) < i_lists) && (r_cnt[l] == '0) && !r_end[l]) begin
                w_stall = 1'b1;
            end
        end
    end

    assign w_found = r_nv[1];
    assign w_best  = r_ni[1];
    assign w_go    = !r_pend || !i_res_full;
    assign w_fetch = (r_cnt[w_best] > CNT_W'(1));
    assign w_rp_nx = (r_rp[w_best] == PTR_W'(BUFFER_DEPTH - 1)) ? '0
                                                              : r_rp[w_best] + PTR_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kwsm_pkg::BK_IDLE: begin
                if (!i_cmd_empty && !w_skip) begin
                    if (w_kind == kwsm_pkg::CMD_ELEM && w_full) begin
                        n_state = kwsm_pkg::BK_ERROR;
                    end else begin
                        n_state = kwsm_pkg::BK_SETTLE;
                    end
                end
            end
            kwsm_pkg::BK_ERROR: begin
                if (!i_res_full) begin
                    n_state = kwsm_pkg::BK_IDLE;
                end
            end
            kwsm_pkg::BK_SETTLE: begin
                if (r_wait == WAIT_W'(LV - 1)) begin
                    n_state = kwsm_pkg::BK_DECIDE;
                end
            end
            kwsm_pkg::BK_DECIDE: begin
                if (w_go) begin
                    if (w_stall || !w_found) begin
                        n_state = kwsm_pkg::BK_IDLE;
                    end else if (w_fetch) begin
                        n_state = kwsm_pkg::BK_FETCH;
                    end else begin
                        n_state = kwsm_pkg::BK_SETTLE;
                    end
                end
            end
            kwsm_pkg::BK_FETCH: begin
                n_state = kwsm_pkg::BK_SETTLE;
            end
            default: begin
                n_state = kwsm_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        n_cnt      = r_cnt;
        n_rp       = r_rp;
        n_end      = r_end;
        n_head     = r_head;
        n_pend     = r_pend;
        n_pkey     = r_pkey;
        n_pidx     = r_pidx;
        n_wait     = (r_state == kwsm_pkg::BK_SETTLE) ? r_wait + WAIT_W'(1) : '0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res_data = '0;
        w_we       = 1'b0;
        w_waddr    = f_addr(w_li, w_slot);
        w_raddr    = f_addr(w_best, w_rp_nx);
        unique case (r_state)
            kwsm_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (!w_skip) begin
                        if (w_kind == kwsm_pkg::CMD_EMPTY) begin
                            n_end[w_li] = 1'b1;
                        end else if (w_full) begin
                            n_end[w_li] = w_fin;
                            n_pidx      = w_li;
                        end else begin
                            w_we        = 1'b1;
                            n_cnt[w_li] = r_cnt[w_li] + CNT_W'(1);
                            n_end[w_li] = w_fin;
                            if (r_cnt[w_li] == '0) begin
                                n_head[w_li] = w_key;
                            end
                        end
                    end
                end
            end
            kwsm_pkg::BK_ERROR: begin
                o_res_push                = 1'b1;
                o_res_data.source_list    = IDX_W'(r_pidx);
                o_res_data.run_last       = 1'b1;
                o_res_data.overflow_error = 1'b1;
            end
            kwsm_pkg::BK_SETTLE: begin
            end
            kwsm_pkg::BK_DECIDE: begin
                // The held result is released once the next decision shows
                // whether it ends the run or the whole merge.
                o_res_push              = r_pend;
                o_res_data.merged_value = VALUE_W'(r_pkey);
                o_res_data.source_list  = IDX_W'(r_pidx);
                o_res_data.run_last     = w_stall || !w_found;
                o_res_data.merge_done   = !w_stall && !w_found;
                if (w_go) begin
                    if (w_stall) begin
                        n_pend = 1'b0;
                    end else if (!w_found) begin
                        n_pend = 1'b0;
                        for (int l = 0; l < MAX_LISTS; l++) begin
                            n_cnt[l] = '0;
                            n_rp[l]  = '0;
                            n_end[l] = 1'b0;
                        end
                    end else begin
                        n_pend         = 1'b1;
                        n_pkey         = r_nk[1];
                        n_pidx         = w_best;
                        n_rp[w_best]   = w_rp_nx;
                        n_cnt[w_best]  = r_cnt[w_best] - CNT_W'(1);
                    end
                end
            end
            kwsm_pkg::BK_FETCH: begin
                n_head[r_pidx] = signed'(w_rdata);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwsm_pkg::BK_IDLE;
            r_pend  <= 1'b0;
            r_wait  <= '0;
            for (int l = 0; l < MAX_LISTS; l++) begin
                r_cnt[l] <= '0;
                r_rp[l]  <= '0;
                r_end[l] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_wait  <= n_wait;
            r_cnt   <= n_cnt;
            r_rp    <= n_rp;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_pkey <= n_pkey;
        r_pidx <= n_pidx;
    end

    kwsm_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MEM_D)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

// ===== rtl/k_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_merge: merge of up to MAX_LISTS ascending lists into one stream
// An accepted item is dispatched to the merge engine from the command queue;
// each merged result is chosen through the registered minimum tree, with a
// buffer RAM read after it when its list still holds further elements. A
// result reaches the outputs through the registers of the result queue.
// Reset (synchronous) empties both queues, clears counts, read pointers and
// end flags and sets lists_in_use to MAX_LISTS; the element RAM is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module k_way_sorted_merge #(
    parameter int MAX_LISTS    = kwsm_pkg::MAX_LISTS_DEF,
    parameter int BUFFER_DEPTH = kwsm_pkg::BUFFER_DEPTH_DEF,
    parameter int KEY_WIDTH    = kwsm_pkg::KEY_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kwsm_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [kwsm_pkg::IDX_W-1:0]          i_list_index,
    input  logic signed [kwsm_pkg::VALUE_W-1:0] i_element_value,
    input  logic                                i_list_final,
    input  logic                                i_list_empty,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [kwsm_pkg::VALUE_W-1:0] o_merged_value,
    output logic [kwsm_pkg::IDX_W-1:0]          o_source_list,
    output logic                                o_run_last,
    output logic                                o_merge_done,
    output logic                                o_overflow_error
);

    localparam int CMD_W  = kwsm_pkg::f_cmd_w(MAX_LISTS, KEY_WIDTH);
    localparam int LCNT_W = kwsm_pkg::f_lcnt_w(MAX_LISTS);
    localparam int RES_W  = $bits(kwsm_pkg::t_result);

    logic              w_cmd_push, w_cmd_full, w_cmd_pop, w_cmd_empty;
    logic [CMD_W-1:0]  w_cmd_in, w_cmd_out;
    logic [LCNT_W-1:0] w_lists;
    logic              w_res_push, w_res_full;
    kwsm_pkg::t_result w_res_in, w_res_out;
    logic [RES_W-1:0]  w_res_flat;

    kwsm_front #(
        .MAX_LISTS (MAX_LISTS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_push       (push),
        .o_in_full       (full),
        .i_list_index    (i_list_index),
        .i_element_value (i_element_value),
        .i_list_final    (i_list_final),
        .i_list_empty    (i_list_empty),
        .i_cmd_full      (w_cmd_full),
        .o_cmd_push      (w_cmd_push),
        .o_cmd_data      (w_cmd_in),
        .o_lists         (w_lists)
    );

    kwsm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (kwsm_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    kwsm_back #(
        .MAX_LISTS    (MAX_LISTS),
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .KEY_WIDTH    (KEY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lists     (w_lists),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd_data  (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_in)
    );

    kwsm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (kwsm_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_flat),
        .o_empty (empty)
    );

    assign w_res_out        = kwsm_pkg::t_result'(w_res_flat);
    assign o_merged_value   = w_res_out.merged_value;
    assign o_source_list    = w_res_out.source_list;
    assign o_run_last       = w_res_out.run_last;
    assign o_merge_done     = w_res_out.merge_done;
    assign o_overflow_error = w_res_out.overflow_error;

endmodule
